FILE: src/lpr_pkg.sv
package lpr_pkg;

    // field widths
    localparam int ADDR_BITS   = 32;
    localparam int LEN_W       = 6;
    localparam int PORT_W      = 4;
    localparam int TTL_W       = 8;
    localparam int STATUS_W    = 3;

    // table geometry
    localparam int DEF_ROUTE_ENTRIES = 64;
    localparam int PORT_COUNT        = 16;

    // limits
    localparam logic [LEN_W-1:0] MAX_LEN     = LEN_W'(ADDR_BITS);
    localparam logic [TTL_W-1:0] TTL_MIN_FWD = TTL_W'(1);

    // transaction kinds
    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_ROUTE = 1'b1;

    // result codes
    typedef enum logic [STATUS_W-1:0] {
        ST_STORED    = 3'd0,
        ST_FORWARDED = 3'd1,
        ST_EXPIRED   = 3'd2,
        ST_NOROUTE   = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

    // item held for the whole scan, seen by every cell
    typedef struct packed {
        logic                 func;
        logic [ADDR_BITS-1:0] key;
        logic [LEN_W-1:0]     len;
    } t_query;

    // table write, broadcast at the end of an add
    typedef struct packed {
        logic                 en;
        logic                 direct;
        logic [ADDR_BITS-1:0] gateway;
        logic [PORT_W-1:0]    port;
    } t_wr;

    // scan token handed from cell to cell
    typedef struct packed {
        logic                 valid;
        logic                 match_found;
        logic                 free_found;
        logic                 best_found;
        logic [LEN_W-1:0]     best_len;
        logic                 best_direct;
        logic [ADDR_BITS-1:0] best_gateway;
        logic [PORT_W-1:0]    best_port;
    } t_acc;

    // top len bits set, len already limited to 32
    function automatic logic [ADDR_BITS-1:0] lpr_len_mask(input logic [LEN_W-1:0] len);
        logic [ADDR_BITS-1:0] ones;
        ones = '1;
        return ~(ones >> len);
    endfunction

endpackage

FILE: src/lpr_item_if.sv
interface lpr_item_if
    import lpr_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 func;
    logic [ADDR_BITS-1:0] route_prefix_in;
    logic [LEN_W-1:0]     route_length;
    logic                 has_gateway;
    logic [ADDR_BITS-1:0] gateway_addr;
    logic [PORT_W-1:0]    route_port;
    logic [ADDR_BITS-1:0] dest_addr;
    logic [TTL_W-1:0]     hops_left;

    modport source (
        output valid, func, route_prefix_in, route_length, has_gateway,
               gateway_addr, route_port, dest_addr, hops_left,
        input  ready
    );

    modport sink (
        input  valid, func, route_prefix_in, route_length, has_gateway,
               gateway_addr, route_port, dest_addr, hops_left,
        output ready
    );
endinterface

FILE: src/lpr_result_if.sv
interface lpr_result_if
    import lpr_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [PORT_W-1:0]    out_port;
    logic [ADDR_BITS-1:0] hop_addr;
    logic [TTL_W-1:0]     hops_out;

    modport source (
        output valid, status, out_port, hop_addr, hops_out,
        input  ready
    );

    modport sink (
        input  valid, status, out_port, hop_addr, hops_out,
        output ready
    );
endinterface

FILE: src/lpr_cell.sv
module lpr_cell
    import lpr_pkg::*;
#(
    parameter int IDX_W = 6,
    parameter int INDEX = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_query           i_query,
    input  t_wr              i_wr,
    input  logic [IDX_W-1:0] i_wr_idx,
    input  t_acc             i_acc,
    input  logic [IDX_W-1:0] i_match_idx,
    input  logic [IDX_W-1:0] i_free_idx,
    output t_acc             o_acc,
    output logic [IDX_W-1:0] o_match_idx,
    output logic [IDX_W-1:0] o_free_idx
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic                 r_valid;
    logic [ADDR_BITS-1:0] r_prefix;
    logic [LEN_W-1:0]     r_len;
    logic                 r_direct;
    logic [ADDR_BITS-1:0] r_gateway;
    logic [PORT_W-1:0]    r_port;

    t_acc                 r_acc;
    t_acc                 n_acc;
    logic [IDX_W-1:0]     r_match_idx;
    logic [IDX_W-1:0]     n_match_idx;
    logic [IDX_W-1:0]     r_free_idx;
    logic [IDX_W-1:0]     n_free_idx;

    logic                 wr_here;
    logic                 same_route;
    logic                 dest_hit;

    assign wr_here = i_wr.en && (i_wr_idx == MY_IDX);

    // entry valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (wr_here) begin
            r_valid <= 1'b1;
        end
    end

    // entry contents
    always_ff @(posedge i_clk) begin
        if (wr_here) begin
            r_prefix  <= i_query.key;
            r_len     <= i_query.len;
            r_direct  <= i_wr.direct;
            r_gateway <= i_wr.gateway;
            r_port    <= i_wr.port;
        end
    end

    // compares against the held item
    assign same_route = r_valid && (r_len == i_query.len) && (r_prefix == i_query.key);
    assign dest_hit   = r_valid && ((i_query.key & lpr_len_mask(r_len)) == r_prefix);

    // fold this entry into the passing token
    always_comb begin
        n_acc       = i_acc;
        n_match_idx = i_match_idx;
        n_free_idx  = i_free_idx;
        if (same_route && !i_acc.match_found) begin
            n_acc.match_found = 1'b1;
            n_match_idx       = MY_IDX;
        end
        if (!r_valid && !i_acc.free_found) begin
            n_acc.free_found = 1'b1;
            n_free_idx       = MY_IDX;
        end
        if (i_query.func == FUNC_ROUTE && dest_hit
            && (!i_acc.best_found || r_len > i_acc.best_len)) begin
            n_acc.best_found   = 1'b1;
            n_acc.best_len     = r_len;
            n_acc.best_direct  = r_direct;
            n_acc.best_gateway = r_gateway;
            n_acc.best_port    = r_port;
        end
    end

    // hand the token on to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else begin
            r_acc <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_match_idx <= n_match_idx;
        r_free_idx  <= n_free_idx;
    end

    assign o_acc       = r_acc;
    assign o_match_idx = r_match_idx;
    assign o_free_idx  = r_free_idx;

endmodule

FILE: src/ipv4_longest_prefix_router_unit.sv
// IPv4 longest-prefix route lookup with a table of ROUTE_ENTRIES routes, one per cell in a
// chain. An add transaction stores a route (prefix masked to its length, length capped at 32),
// overwriting a route of equal prefix and length or else taking the lowest free entry, and
// answers table-full when none is free. A route transaction with time-to-live of 1 or less is
// answered as expired; otherwise the longest matching route gives interface and next hop (the
// destination for a direct route) with time-to-live decremented, or no-route. One transaction
// is in work at a time: a scan token walks the cell chain one cell per cycle, and the next
// transaction is accepted only once the token has left the last cell and the result has been
// taken into the output register. A finished result waits there without blocking the next
// scan. The table is empty after reset with no clearing pass.
module ipv4_longest_prefix_router_unit
    import lpr_pkg::*;
#(
    parameter int ROUTE_ENTRIES = DEF_ROUTE_ENTRIES
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    lpr_item_if.sink     i_item,
    lpr_result_if.source o_result
);

    localparam int IDX_W    = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
    localparam int PORT_NUM = 2 ** PORT_W;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_FINISH = 3'b100
    } t_state;

    t_state               r_state;
    t_state               n_state;
    logic                 r_start;

    // held item
    t_query               r_query;
    logic                 r_direct;
    logic [ADDR_BITS-1:0] r_gateway;
    logic [PORT_W-1:0]    r_port;
    logic [TTL_W-1:0]     r_ttl;

    // captured scan result
    t_acc                 r_acc;
    logic [IDX_W-1:0]     r_match_idx;
    logic [IDX_W-1:0]     r_free_idx;

    // output register
    logic                 r_out_valid;
    t_status              r_status;
    logic [PORT_W-1:0]    r_out_port;
    logic [ADDR_BITS-1:0] r_hop_addr;
    logic [TTL_W-1:0]     r_hops_out;

    logic                 in_fire;
    logic                 finish_go;
    logic [LEN_W-1:0]     len_sat;
    logic [PORT_W-1:0]    port_mod;
    logic [PORT_W-1:0]    port_table [PORT_NUM];
    t_wr                  wr;
    logic [IDX_W-1:0]     wr_idx;
    t_status              n_status;
    logic [PORT_W-1:0]    n_out_port;
    logic [ADDR_BITS-1:0] n_hop_addr;
    logic [TTL_W-1:0]     n_hops_out;

    t_acc                 chain_acc   [ROUTE_ENTRIES+1];
    logic [IDX_W-1:0]     chain_match [ROUTE_ENTRIES+1];
    logic [IDX_W-1:0]     chain_free  [ROUTE_ENTRIES+1];
    logic [ROUTE_ENTRIES:0] tok_v;

    assign i_item.ready = (r_state == S_IDLE);
    assign in_fire      = i_item.valid && i_item.ready;
    assign finish_go    = (r_state == S_FINISH) && (!r_out_valid || o_result.ready);

    // interface number folded into the port range
    for (genvar k = 0; k < PORT_NUM; k++) begin : g_port_table
        localparam int PM = k % PORT_COUNT;
        assign port_table[k] = PORT_W'(PM);
    end
    assign port_mod = port_table[i_item.route_port];

    assign len_sat = (i_item.route_length > MAX_LEN) ? MAX_LEN : i_item.route_length;

    // capture the item on acceptance
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_query.func <= i_item.func;
            r_query.len  <= len_sat;
            r_query.key  <= (i_item.func == FUNC_ROUTE) ? i_item.dest_addr
                          : (i_item.route_prefix_in & lpr_len_mask(len_sat));
            r_direct     <= !i_item.has_gateway;
            r_gateway    <= i_item.gateway_addr;
            r_port       <= port_mod;
            r_ttl        <= i_item.hops_left;
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (chain_acc[ROUTE_ENTRIES].valid) n_state = S_FINISH;
            end
            S_FINISH: begin
                if (finish_go) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_start <= 1'b0;
        end else begin
            r_state <= n_state;
            r_start <= in_fire;
        end
    end

    // token entering the first cell
    always_comb begin
        chain_acc[0]       = '0;
        chain_acc[0].valid = r_start;
    end
    assign chain_match[0] = '0;
    assign chain_free[0]  = '0;

    // the cell chain
    for (genvar i = 0; i < ROUTE_ENTRIES; i++) begin : g_cell
        lpr_cell #(
            .IDX_W (IDX_W),
            .INDEX (i)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_query     (r_query),
            .i_wr        (wr),
            .i_wr_idx    (wr_idx),
            .i_acc       (chain_acc[i]),
            .i_match_idx (chain_match[i]),
            .i_free_idx  (chain_free[i]),
            .o_acc       (chain_acc[i+1]),
            .o_match_idx (chain_match[i+1]),
            .o_free_idx  (chain_free[i+1])
        );
    end

    for (genvar i = 0; i <= ROUTE_ENTRIES; i++) begin : g_tok
        assign tok_v[i] = chain_acc[i].valid;
    end

    // token leaving the last cell
    always_ff @(posedge i_clk) begin
        if (r_state == S_SCAN && chain_acc[ROUTE_ENTRIES].valid) begin
            r_acc       <= chain_acc[ROUTE_ENTRIES];
            r_match_idx <= chain_match[ROUTE_ENTRIES];
            r_free_idx  <= chain_free[ROUTE_ENTRIES];
        end
    end

    // result and table write
    always_comb begin
        wr.en      = 1'b0;
        wr.direct  = r_direct;
        wr.gateway = r_gateway;
        wr.port    = r_port;
        wr_idx     = r_acc.match_found ? r_match_idx : r_free_idx;
        n_status   = ST_STORED;
        n_out_port = '0;
        n_hop_addr = '0;
        n_hops_out = '0;
        if (r_query.func == FUNC_ADD) begin
            if (r_acc.match_found || r_acc.free_found) begin
                wr.en    = finish_go;
                n_status = ST_STORED;
            end else begin
                n_status = ST_FULL;
            end
        end else if (r_ttl <= TTL_MIN_FWD) begin
            n_status = ST_EXPIRED;
        end else if (!r_acc.best_found) begin
            n_status = ST_NOROUTE;
        end else begin
            n_status   = ST_FORWARDED;
            n_out_port = r_acc.best_port;
            n_hop_addr = r_acc.best_direct ? r_query.key : r_acc.best_gateway;
            n_hops_out = r_ttl - TTL_W'(1);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish_go) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish_go) begin
            r_status   <= n_status;
            r_out_port <= n_out_port;
            r_hop_addr <= n_hop_addr;
            r_hops_out <= n_hops_out;
        end
    end

    assign o_result.valid    = r_out_valid;
    assign o_result.status   = r_status;
    assign o_result.out_port = r_out_port;
    assign o_result.hop_addr = r_hop_addr;
    assign o_result.hops_out = r_hops_out;

`ifndef SYNTHESIS
    // at most one scan token in the chain
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(tok_v))
        else $error("more than one scan token in the cell chain");

    // no token travelling while idle
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (tok_v == '0))
        else $error("scan token present while idle");

    // table writes come only from add transactions
    a_wr_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr.en |-> (r_query.func == FUNC_ADD) && (r_state == S_FINISH))
        else $error("table write outside an add finish");

    // a new result follows a finish step
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_FINISH))
        else $error("result appeared without a finished scan");
`endif

endmodule

FILE: test/lpr_route_checker.sv
module lpr_route_checker
    import lpr_pkg::*;
#(
    parameter int ROUTE_ENTRIES = DEF_ROUTE_ENTRIES
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    lpr_item_if   i_item,
    lpr_result_if i_result,
    output int    o_error_count,
    output int    o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // one stored route as the lookup sees it
    typedef struct {
        bit                 used;
        bit [ADDR_BITS-1:0] prefix;
        bit [LEN_W-1:0]     len;
        bit                 direct;
        bit [ADDR_BITS-1:0] gateway;
        bit [PORT_W-1:0]    port;
    } t_route_entry;

    // forwarding decision for one transaction
    typedef struct packed {
        t_status              status;
        logic [PORT_W-1:0]    port;
        logic [ADDR_BITS-1:0] hop;
        logic [TTL_W-1:0]     ttl;
    } t_forward_decision;

    t_route_entry      route_table [ROUTE_ENTRIES];
    t_forward_decision pending_decisions [$];
    int                mismatches = 0;

    assign o_error_count = mismatches;

    // high-order len bits set
    function automatic bit [ADDR_BITS-1:0] prefix_mask(input int unsigned len);
        return (len == 0) ? '0 : ({ADDR_BITS{1'b1}} << (ADDR_BITS - len));
    endfunction

    // add: overwrite an equal route, else lowest free entry, else table full
    function automatic t_forward_decision store_route(
        input logic [ADDR_BITS-1:0] prefix_in,
        input logic [LEN_W-1:0]     len_in,
        input logic                 via_gateway,
        input logic [ADDR_BITS-1:0] gateway,
        input logic [PORT_W-1:0]    port
    );
        t_forward_decision  d;
        int unsigned        len;
        bit [ADDR_BITS-1:0] key;
        int                 hit;
        int                 spare;
        d = '0;
        d.status = ST_STORED;
        len = (len_in > ADDR_BITS) ? ADDR_BITS : len_in;
        key = prefix_in & prefix_mask(len);
        hit = -1;
        spare = -1;
        for (int i = 0; i < ROUTE_ENTRIES; i++) begin
            if (route_table[i].used) begin
                if (hit < 0 && route_table[i].len == len && route_table[i].prefix == key)
                    hit = i;
            end else if (spare < 0) begin
                spare = i;
            end
        end
        if (hit < 0)
            hit = spare;
        if (hit < 0) begin
            d.status = ST_FULL;
            return d;
        end
        route_table[hit].used    = 1'b1;
        route_table[hit].prefix  = key;
        route_table[hit].len     = LEN_W'(len);
        route_table[hit].direct  = !via_gateway;
        route_table[hit].gateway = gateway;
        route_table[hit].port    = PORT_W'(port % PORT_COUNT);
        return d;
    endfunction

    // datagram: expiry first, then longest matching route
    function automatic t_forward_decision route_datagram(
        input logic [ADDR_BITS-1:0] dest,
        input logic [TTL_W-1:0]     ttl
    );
        t_forward_decision d;
        int                best;
        d = '0;
        if (ttl <= TTL_MIN_FWD) begin
            d.status = ST_EXPIRED;
            return d;
        end
        best = -1;
        for (int i = 0; i < ROUTE_ENTRIES; i++) begin
            if (route_table[i].used &&
                (dest & prefix_mask(route_table[i].len)) == route_table[i].prefix &&
                (best < 0 || route_table[i].len > route_table[best].len))
                best = i;
        end
        if (best < 0) begin
            d.status = ST_NOROUTE;
            return d;
        end
        d.status = ST_FORWARDED;
        d.port   = route_table[best].port;
        d.hop    = route_table[best].direct ? dest : route_table[best].gateway;
        d.ttl    = ttl - 1'b1;
        return d;
    endfunction

    task automatic compare_field(input string field, input logic [ADDR_BITS-1:0] want,
                                 input logic [ADDR_BITS-1:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch: expected %h actual %h", $time, field, want, got);
        end
    endtask

    // results retire the oldest decision before the new transaction is predicted
    always @(posedge i_clk) begin
        t_forward_decision want;
        if (!i_rst_n) begin
            foreach (route_table[i])
                route_table[i].used = 1'b0;
            pending_decisions.delete();
        end else begin
            if (i_result.valid && i_result.ready) begin
                if (pending_decisions.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result: expected none actual %0d %h %h %h",
                             $time, i_result.status, i_result.out_port, i_result.hop_addr,
                             i_result.hops_out);
                end else begin
                    want = pending_decisions.pop_front();
                    compare_field("status", 32'(want.status), 32'(i_result.status));
                    compare_field("out_port", 32'(want.port), 32'(i_result.out_port));
                    compare_field("hop_addr", want.hop, i_result.hop_addr);
                    compare_field("hops_out", 32'(want.ttl), 32'(i_result.hops_out));
                end
            end
            if (i_item.valid && i_item.ready) begin
                if (i_item.func == FUNC_ADD)
                    pending_decisions.push_back(store_route(i_item.route_prefix_in,
                        i_item.route_length, i_item.has_gateway, i_item.gateway_addr,
                        i_item.route_port));
                else
                    pending_decisions.push_back(route_datagram(i_item.dest_addr,
                        i_item.hops_left));
            end
        end
        o_outstanding <= pending_decisions.size();
    end

endmodule

FILE: test/tb.sv
module tb
    import lpr_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROUTES          = DEF_ROUTE_ENTRIES;
    localparam int RANDOM_ITEMS    = 480;
    localparam int HOLD_OFF_AT     = 200;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_AT        = 340;
    localparam int QUIET_FROM      = 420;
    localparam int IDLE_LIMIT      = 2500;

    typedef struct packed {
        logic                 func;
        logic [ADDR_BITS-1:0] route_prefix_in;
        logic [LEN_W-1:0]     route_length;
        logic                 has_gateway;
        logic [ADDR_BITS-1:0] gateway_addr;
        logic [PORT_W-1:0]    route_port;
        logic [ADDR_BITS-1:0] dest_addr;
        logic [TTL_W-1:0]     hops_left;
    } t_route_req;

    logic clk;
    logic rst_n;
    int   sent_count;
    logic quiet_tail;
    int   error_count;
    int   outstanding;
    int   stalled_cycles;

    lpr_item_if   item_if ();
    lpr_result_if result_if ();

    ipv4_longest_prefix_router_unit #(
        .ROUTE_ENTRIES(ROUTES)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_item  (item_if),
        .o_result(result_if)
    );

    lpr_route_checker #(
        .ROUTE_ENTRIES(ROUTES)
    ) route_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_item       (item_if),
        .i_result     (result_if),
        .o_error_count(error_count),
        .o_outstanding(outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // route add with noise on the datagram fields
    function automatic t_route_req add_route_req(input logic [ADDR_BITS-1:0] prefix,
                                                 input logic [LEN_W-1:0] len,
                                                 input logic via_gateway,
                                                 input logic [ADDR_BITS-1:0] gateway,
                                                 input logic [PORT_W-1:0] port);
        t_route_req req;
        req.func            = FUNC_ADD;
        req.route_prefix_in = prefix;
        req.route_length    = len;
        req.has_gateway     = via_gateway;
        req.gateway_addr    = gateway;
        req.route_port      = port;
        req.dest_addr       = $urandom;
        req.hops_left       = TTL_W'($urandom);
        return req;
    endfunction

    // datagram with noise on the route fields
    function automatic t_route_req datagram_req(input logic [ADDR_BITS-1:0] dest,
                                                input logic [TTL_W-1:0] ttl);
        t_route_req req;
        req.func            = FUNC_ROUTE;
        req.route_prefix_in = $urandom;
        req.route_length    = LEN_W'($urandom);
        req.has_gateway     = 1'($urandom);
        req.gateway_addr    = $urandom;
        req.route_port      = PORT_W'($urandom);
        req.dest_addr       = dest;
        req.hops_left       = ttl;
        return req;
    endfunction

    // present one transaction and hold it until taken
    task automatic offer(input t_route_req req);
        item_if.valid           <= 1'b1;
        item_if.func            <= req.func;
        item_if.route_prefix_in <= req.route_prefix_in;
        item_if.route_length    <= req.route_length;
        item_if.has_gateway     <= req.has_gateway;
        item_if.gateway_addr    <= req.gateway_addr;
        item_if.route_port      <= req.route_port;
        item_if.dest_addr       <= req.dest_addr;
        item_if.hops_left       <= req.hops_left;
        do @(posedge clk); while (!item_if.ready);
        sent_count <= sent_count + 1;
    endtask

    task automatic sender_gap(input int cycles);
        item_if.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // stimulus and verdict
    initial begin
        t_route_req           req;
        t_route_req           prior;
        t_route_req           learned [$];
        logic [ADDR_BITS-1:0] bases [8];
        logic [ADDR_BITS-1:0] host;
        logic [ADDR_BITS-1:0] dest;
        logic [LEN_W-1:0]     len;
        logic [TTL_W-1:0]     ttl;
        int                   pick;

        rst_n                   <= 1'b0;
        item_if.valid           <= 1'b0;
        item_if.func            <= FUNC_ADD;
        item_if.route_prefix_in <= '0;
        item_if.route_length    <= '0;
        item_if.has_gateway     <= 1'b0;
        item_if.gateway_addr    <= '0;
        item_if.route_port      <= '0;
        item_if.dest_addr       <= '0;
        item_if.hops_left       <= '0;
        sent_count              <= 0;
        quiet_tail              <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table: no route, expiry at both low ttl values
        offer(datagram_req(32'hC0A8_0105, 8'd64));
        offer(datagram_req(32'hFFFF_FFFF, 8'd0));
        offer(datagram_req(32'h0000_0000, 8'd1));
        // direct /24 with a /32 via gateway inside it
        offer(add_route_req(32'hC0A8_01FF, 6'd24, 1'b0, 32'hDEAD_BEEF, 4'd3));
        offer(datagram_req(32'hC0A8_0105, 8'd64));
        offer(add_route_req(32'hC0A8_0107, 6'd32, 1'b1, 32'hFFFF_FFFF, 4'd7));
        offer(datagram_req(32'hC0A8_0107, 8'd2));
        offer(datagram_req(32'hC0A8_0106, 8'd255));
        offer(datagram_req(32'hC0A8_0207, 8'd10));
        // same /24 again now with a gateway, replaces the entry
        offer(add_route_req(32'hC0A8_0100, 6'd24, 1'b1, 32'h0000_0000, 4'd9));
        offer(datagram_req(32'hC0A8_01AA, 8'd3));
        // single top bit
        offer(add_route_req(32'hFFFF_FFFF, 6'd1, 1'b0, 32'h0000_0000, 4'd0));
        offer(datagram_req(32'hFFFF_FFFF, 8'd2));
        // oversized lengths behave as /32 and land on one entry
        offer(add_route_req(32'h0102_0304, 6'd63, 1'b1, 32'h0A0B_0C0D, 4'd5));
        offer(datagram_req(32'h0102_0304, 8'd9));
        offer(add_route_req(32'h0102_0304, 6'd40, 1'b0, 32'h0A0B_0C0D, 4'd15));
        offer(datagram_req(32'h0102_0304, 8'd9));
        offer(datagram_req(32'h0102_0304, 8'd1));
        // default route matches everything, longer routes still win
        offer(add_route_req(32'hFFFF_FFFF, 6'd0, 1'b1, 32'h0A00_0001, 4'd12));
        offer(datagram_req(32'h1234_5678, 8'd2));
        offer(datagram_req(32'hC0A8_0107, 8'd128));

        // random traffic around a few nested address families
        foreach (bases[b])
            bases[b] = $urandom;
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == DRAIN_AT) begin
                item_if.valid <= 1'b0;
                do @(posedge clk); while (outstanding != 0);
            end else if (k < QUIET_FROM && $urandom_range(0, 4) == 0) begin
                sender_gap($urandom_range(1, 13));
            end
            if (k == QUIET_FROM)
                quiet_tail <= 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                len = ($urandom_range(0, 19) == 0) ? LEN_W'($urandom_range(33, 63))
                                                   : LEN_W'($urandom_range(0, 32));
                host = 32'hFFFF_FFFF >> len;
                if (pick < 10 && learned.size() != 0) begin
                    // re-add a known route with new next hop and port
                    prior = learned[$urandom_range(0, learned.size() - 1)];
                    host = 32'hFFFF_FFFF >> prior.route_length;
                    req = add_route_req(prior.route_prefix_in ^ ($urandom & host),
                                        prior.route_length, 1'($urandom), $urandom,
                                        PORT_W'($urandom));
                end else if (pick < 32) begin
                    req = add_route_req(bases[$urandom_range(0, 7)] ^ ($urandom & host), len,
                                        1'($urandom), $urandom, PORT_W'($urandom));
                end else begin
                    req = add_route_req($urandom, len, 1'($urandom), $urandom,
                                        PORT_W'($urandom));
                end
                learned.push_back(req);
            end else begin
                if (pick < 85) begin
                    dest = bases[$urandom_range(0, 7)] ^
                           ($urandom & (32'hFFFF_FFFF >> $urandom_range(0, 32)));
                end else if (pick < 95 && learned.size() != 0) begin
                    prior = learned[$urandom_range(0, learned.size() - 1)];
                    dest = prior.route_prefix_in ^
                           ($urandom & (32'hFFFF_FFFF >> prior.route_length));
                end else begin
                    dest = $urandom;
                end
                ttl = ($urandom_range(0, 9) == 0) ? TTL_W'($urandom_range(0, 1))
                                                  : TTL_W'($urandom_range(2, 255));
                req = datagram_req(dest, ttl);
            end
            offer(req);
        end

        // drain, settle, verdict
        item_if.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (ROUTES + 8) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // result side back-pressure, with one long hold-off to fill the block
    initial begin
        int span;
        bit held;
        held = 1'b0;
        result_if.ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            if (quiet_tail) begin
                result_if.ready <= 1'b1;
                span = 1;
            end else if (!held && sent_count >= HOLD_OFF_AT) begin
                held = 1'b1;
                result_if.ready <= 1'b0;
                span = HOLD_OFF_CYCLES;
            end else if ($urandom_range(0, 3) == 0) begin
                result_if.ready <= 1'b0;
                span = $urandom_range(1, 13);
            end else begin
                result_if.ready <= 1'b1;
                span = $urandom_range(1, 20);
            end
            repeat (span) @(posedge clk);
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge clk) begin
        if (!rst_n || (item_if.valid && item_if.ready) || (result_if.valid && result_if.ready)) begin
            stalled_cycles <= 0;
        end else if (stalled_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            stalled_cycles <= stalled_cycles + 1;
        end
    end

endmodule
